// ===== design/q4sd_pkg.sv =====
package q4sd_pkg;

   localparam int NODES    = 4;
   localparam int W_NAT    = 18;               // Q2.16 natural coordinate
   localparam int W_CRD    = 32;               // node coordinate
   localparam int W_DN     = W_NAT + 1;        // natural derivative, 16 fraction bits
   localparam int W_PRD    = W_CRD + W_DN;     // coordinate times natural derivative
   localparam int W_J      = W_PRD + 2;        // Jacobian entry, sum of four products
   localparam int W_JL     = 26;               // low slice of a split Jacobian entry
   localparam int W_JH     = W_J - W_JL;       // high slice, signed
   localparam int W_PP     = 2 * W_JH;         // det partial product
   localparam int W_NP     = W_DN + W_JH;      // numerator partial product
   localparam int W_DET    = 2 * W_J + 1;      // exact determinant
   localparam int W_NUM    = W_DN + W_J + 1;   // exact derivative numerator
   localparam int QB       = 33;               // quotient bits kept
   localparam int DET_SHIFT = 36;              // extra fraction bits of det
   localparam int W_DETO   = 64;
   localparam int W_OUT    = 32;
   localparam int NUMS     = 2 * NODES;        // dx and dy per node
   localparam int W_REQ    = 296;
   localparam int W_RSP    = W_DETO + NUMS * W_OUT;
   localparam int IN_NODE_LSB = 2 * W_NAT;

   localparam logic signed [W_DN-1:0] NAT_ONE = W_DN'(65536);

   localparam logic [W_DETO-1:0] DET_MAX = {1'b0, {(W_DETO-1){1'b1}}};
   localparam logic [W_DETO-1:0] DET_MIN = {1'b1, {(W_DETO-1){1'b0}}};
   localparam logic [W_OUT-1:0]  OUT_MAX = {1'b0, {(W_OUT-1){1'b1}}};
   localparam logic [W_OUT-1:0]  OUT_MIN = {1'b1, {(W_OUT-1){1'b0}}};
   localparam logic [QB-1:0]     Q_POS_LIM = QB'(33'h0_7FFF_FFFF);
   localparam logic [QB-1:0]     Q_NEG_LIM = QB'(33'h0_8000_0000);

   typedef struct packed {
      logic [W_DETO-1:0] det;
      logic              singular;
      logic [NUMS-1:0]   neg;
      logic [NUMS-1:0]   ovf;
   } meta_type;

endpackage

// ===== design/quad4_shape_derivatives_unit.sv =====
// Pipeline: 6 arithmetic stages, 33 divider stages and one output register.
// Throughput: one request per cycle; every stage has its own valid bit and
// stalls only when the stage after it is full, so bubbles are squeezed out.
// Reset clears the valid bits only; data registers are not reset.
module quad4_shape_derivatives_unit import q4sd_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // xi_coord, eta_coord, node_x0, node_y0, node_x1, node_y1, node_x2,
   // node_y2, node_x3, node_y3, zero pad
   input  logic [W_REQ-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // det_jacobian, dn0_dx, dn0_dy, dn1_dx, dn1_dy, dn2_dx, dn2_dy, dn3_dx, dn3_dy
   output logic [W_RSP-1:0] rsp_tdata,
   // singular
   output logic             rsp_tuser
);

   localparam int W_N      = W_NUM + 2 * COORD_FRAC_BITS;
   localparam int W_DM     = W_DET;
   localparam int W_X      = (W_N > W_DM + QB + 1) ? W_N : W_DM + QB + 1;
   localparam int DIV_BASE = 7;
   localparam int NS       = DIV_BASE + QB;

   logic [NS:1] en;
   logic [NS:1] v_ff;

   // ---------------- handshake chain ----------------
   assign en[NS] = !v_ff[NS] || rsp_tready;
   for (genvar k = 1; k < NS; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: natural derivatives and coordinate products ----------------
   logic signed [W_DN-1:0]  xi_s, eta_s;
   logic signed [W_DN-1:0]  nd0 [NODES];
   logic signed [W_DN-1:0]  nd1 [NODES];
   logic signed [W_CRD-1:0] cx [NODES];
   logic signed [W_CRD-1:0] cy [NODES];

   logic signed [W_PRD-1:0] s1_pxa_ff [NODES];
   logic signed [W_PRD-1:0] s1_pxb_ff [NODES];
   logic signed [W_PRD-1:0] s1_pya_ff [NODES];
   logic signed [W_PRD-1:0] s1_pyb_ff [NODES];
   logic signed [W_DN-1:0]  s1_d0_ff [NODES];
   logic signed [W_DN-1:0]  s1_d1_ff [NODES];

   always_comb begin
      xi_s  = {req_tdata[W_NAT-1], req_tdata[W_NAT-1:0]};
      eta_s = {req_tdata[2*W_NAT-1], req_tdata[2*W_NAT-1:W_NAT]};
      nd0[0] = -(NAT_ONE - eta_s);  nd1[0] = -(NAT_ONE - xi_s);
      nd0[1] =  (NAT_ONE - eta_s);  nd1[1] = -(NAT_ONE + xi_s);
      nd0[2] =  (NAT_ONE + eta_s);  nd1[2] =  (NAT_ONE + xi_s);
      nd0[3] = -(NAT_ONE + eta_s);  nd1[3] =  (NAT_ONE - xi_s);
      for (int i = 0; i < NODES; i++) begin
         cx[i] = req_tdata[IN_NODE_LSB + 2*W_CRD*i +: W_CRD];
         cy[i] = req_tdata[IN_NODE_LSB + 2*W_CRD*i + W_CRD +: W_CRD];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < NODES; i++) begin
            s1_pxa_ff[i] <= cx[i] * nd0[i];
            s1_pxb_ff[i] <= cx[i] * nd1[i];
            s1_pya_ff[i] <= cy[i] * nd0[i];
            s1_pyb_ff[i] <= cy[i] * nd1[i];
            s1_d0_ff[i]  <= nd0[i];
            s1_d1_ff[i]  <= nd1[i];
         end
      end
   end

   // ---------------- stage 2: Jacobian sums ----------------
   logic signed [W_J-1:0]  s2_j00_ff, s2_j01_ff, s2_j10_ff, s2_j11_ff;
   logic signed [W_DN-1:0] s2_d0_ff [NODES];
   logic signed [W_DN-1:0] s2_d1_ff [NODES];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_j00_ff <= W_J'(s1_pxa_ff[0]) + W_J'(s1_pxa_ff[1])
                    + W_J'(s1_pxa_ff[2]) + W_J'(s1_pxa_ff[3]);
         s2_j01_ff <= W_J'(s1_pxb_ff[0]) + W_J'(s1_pxb_ff[1])
                    + W_J'(s1_pxb_ff[2]) + W_J'(s1_pxb_ff[3]);
         s2_j10_ff <= W_J'(s1_pya_ff[0]) + W_J'(s1_pya_ff[1])
                    + W_J'(s1_pya_ff[2]) + W_J'(s1_pya_ff[3]);
         s2_j11_ff <= W_J'(s1_pyb_ff[0]) + W_J'(s1_pyb_ff[1])
                    + W_J'(s1_pyb_ff[2]) + W_J'(s1_pyb_ff[3]);
         s2_d0_ff  <= s1_d0_ff;
         s2_d1_ff  <= s1_d1_ff;
      end
   end

   // ---------------- stage 3: split partial products ----------------
   // each entry is split into a signed high slice and a zero-extended low slice
   logic signed [W_JH-1:0] j00h, j00l, j01h, j01l, j10h, j10l, j11h, j11l;
   logic signed [W_PP-1:0] s3_dp_ff [8];
   logic signed [W_NP-1:0] s3_np_ff [NUMS][4];

   always_comb begin
      j00h = s2_j00_ff[W_J-1:W_JL];  j00l = {1'b0, s2_j00_ff[W_JL-1:0]};
      j01h = s2_j01_ff[W_J-1:W_JL];  j01l = {1'b0, s2_j01_ff[W_JL-1:0]};
      j10h = s2_j10_ff[W_J-1:W_JL];  j10l = {1'b0, s2_j10_ff[W_JL-1:0]};
      j11h = s2_j11_ff[W_J-1:W_JL];  j11l = {1'b0, s2_j11_ff[W_JL-1:0]};
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_dp_ff[0] <= j00h * j11h;
         s3_dp_ff[1] <= j00h * j11l;
         s3_dp_ff[2] <= j00l * j11h;
         s3_dp_ff[3] <= j00l * j11l;
         s3_dp_ff[4] <= j01h * j10h;
         s3_dp_ff[5] <= j01h * j10l;
         s3_dp_ff[6] <= j01l * j10h;
         s3_dp_ff[7] <= j01l * j10l;
         for (int i = 0; i < NODES; i++) begin
            // dN/dx numerator: d0*J11 - d1*J10
            s3_np_ff[2*i][0]   <= s2_d0_ff[i] * j11h;
            s3_np_ff[2*i][1]   <= s2_d0_ff[i] * j11l;
            s3_np_ff[2*i][2]   <= s2_d1_ff[i] * j10h;
            s3_np_ff[2*i][3]   <= s2_d1_ff[i] * j10l;
            // dN/dy numerator: d1*J00 - d0*J01
            s3_np_ff[2*i+1][0] <= s2_d1_ff[i] * j00h;
            s3_np_ff[2*i+1][1] <= s2_d1_ff[i] * j00l;
            s3_np_ff[2*i+1][2] <= s2_d0_ff[i] * j01h;
            s3_np_ff[2*i+1][3] <= s2_d0_ff[i] * j01l;
         end
      end
   end

   // ---------------- stage 4: recombine ----------------
   logic signed [W_DET-1:0] s4_det_ff;
   logic signed [W_NUM-1:0] s4_num_ff [NUMS];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_det_ff <= (W_DET'(s3_dp_ff[0]) <<< (2*W_JL))
                    + (W_DET'(s3_dp_ff[1]) <<< W_JL)
                    + (W_DET'(s3_dp_ff[2]) <<< W_JL)
                    +  W_DET'(s3_dp_ff[3])
                    - (W_DET'(s3_dp_ff[4]) <<< (2*W_JL))
                    - (W_DET'(s3_dp_ff[5]) <<< W_JL)
                    - (W_DET'(s3_dp_ff[6]) <<< W_JL)
                    -  W_DET'(s3_dp_ff[7]);
         for (int n = 0; n < NUMS; n++) begin
            s4_num_ff[n] <= (W_NUM'(s3_np_ff[n][0]) <<< W_JL) + W_NUM'(s3_np_ff[n][1])
                          - (W_NUM'(s3_np_ff[n][2]) <<< W_JL) - W_NUM'(s3_np_ff[n][3]);
         end
      end
   end

   // ---------------- stage 5: magnitudes, det output ----------------
   logic                    det_neg;
   logic [W_DM-1:0]         dmag;
   logic signed [W_DET-1:0] dz;
   logic                    dz_fits;
   logic [W_DETO-1:0]       det_o;
   logic [NUMS-1:0]         nneg;
   logic [W_NUM-1:0]        nabs [NUMS];

   logic [W_DM-1:0]   s5_dmag_ff;
   logic [W_N-1:0]    s5_nmag_ff [NUMS];
   logic [NUMS-1:0]   s5_neg_ff;
   logic [W_DETO-1:0] s5_det_ff;
   logic              s5_sing_ff;

   always_comb begin
      det_neg = s4_det_ff[W_DET-1];
      dmag    = det_neg ? W_DM'(-s4_det_ff) : W_DM'(s4_det_ff);
      dz      = s4_det_ff >>> DET_SHIFT;
      dz_fits = (&dz[W_DET-1:W_DETO-1]) || !(|dz[W_DET-1:W_DETO-1]);
      det_o   = dz_fits ? dz[W_DETO-1:0] : (det_neg ? DET_MIN : DET_MAX);
      for (int n = 0; n < NUMS; n++) begin
         nneg[n] = s4_num_ff[n][W_NUM-1];
         nabs[n] = nneg[n] ? W_NUM'(-s4_num_ff[n]) : W_NUM'(s4_num_ff[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_dmag_ff <= dmag;
         s5_det_ff  <= det_o;
         s5_sing_ff <= s4_det_ff == '0;
         for (int n = 0; n < NUMS; n++) begin
            s5_nmag_ff[n] <= W_N'(nabs[n]) << (2 * COORD_FRAC_BITS);
            s5_neg_ff[n]  <= nneg[n] != det_neg;
         end
      end
   end

   // ---------------- stage 6: quotient overflow check ----------------
   logic [W_DM-1:0] s6_dmag_ff;
   logic [W_N-1:0]  s6_nmag_ff [NUMS];
   meta_type        s6_meta_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_dmag_ff          <= s5_dmag_ff;
         s6_nmag_ff          <= s5_nmag_ff;
         s6_meta_ff.det      <= s5_det_ff;
         s6_meta_ff.singular <= s5_sing_ff;
         s6_meta_ff.neg      <= s5_neg_ff;
         for (int n = 0; n < NUMS; n++) begin
            s6_meta_ff.ovf[n] <= W_X'(s5_nmag_ff[n]) >= (W_X'(s5_dmag_ff) << QB);
         end
      end
   end

   // ---------------- divider lanes ----------------
   logic [QB-1:0] quo [NUMS];
   meta_type      meta_ff [QB];

   for (genvar n = 0; n < NUMS; n++) begin : g_lane
      q4sd_div_lane #(
         .W_N  (W_N),
         .W_DM (W_DM),
         .W_X  (W_X)
      ) u_lane (
         .clock (clock),
         .en    (en[DIV_BASE+QB-1:DIV_BASE]),
         .num   (s6_nmag_ff[n]),
         .den   (s6_dmag_ff),
         .quo   (quo[n])
      );
   end

   always_ff @(posedge clock) begin
      if (en[DIV_BASE]) begin
         meta_ff[0] <= s6_meta_ff;
      end
      for (int s = 1; s < QB; s++) begin
         if (en[DIV_BASE+s]) begin
            meta_ff[s] <= meta_ff[s-1];
         end
      end
   end

   // ---------------- output register: saturate, zero when singular ----------------
   meta_type         mo;
   logic [W_RSP-1:0] rsp_data_in;
   logic [W_RSP-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   always_comb begin
      mo = meta_ff[QB-1];
      rsp_data_in = '0;
      if (!mo.singular) begin
         rsp_data_in[W_DETO-1:0] = mo.det;
         for (int n = 0; n < NUMS; n++) begin
            if (mo.neg[n]) begin
               rsp_data_in[W_DETO + W_OUT*n +: W_OUT] =
                  (mo.ovf[n] || quo[n] > Q_NEG_LIM) ? OUT_MIN : W_OUT'(-quo[n]);
            end else begin
               rsp_data_in[W_DETO + W_OUT*n +: W_OUT] =
                  (mo.ovf[n] || quo[n] > Q_POS_LIM) ? OUT_MAX : quo[n][W_OUT-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= mo.singular;
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- assertions ----------------
   a_sing_det_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[W_DETO-1:0] == '0)
      else $error("singular request with nonzero det");

   a_sing_deriv_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[W_RSP-1:W_DETO] == '0)
      else $error("singular request with nonzero derivatives");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v_ff[1] && rsp_tvalid && !rsp_tready)
      else $error("input stalled while pipeline not blocked");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== design/q4sd_div_lane.sv =====
module q4sd_div_lane import q4sd_pkg::*; #(
   parameter int W_N  = 105,
   parameter int W_DM = 107,
   parameter int W_X  = 141
) (
   input  logic            clock,
   input  logic [QB-1:0]   en,
   input  logic [W_N-1:0]  num,
   input  logic [W_DM-1:0] den,
   output logic [QB-1:0]   quo
);

   logic [W_X-1:0]  r_ff [QB];
   logic [W_DM-1:0] d_ff [QB];
   logic [QB-1:0]   q_ff [QB];

   // restoring division, one quotient bit per stage, MSB first
   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [W_X-1:0]  r_prev, d_sh, r_in;
      logic [W_DM-1:0] d_prev;
      logic [QB-1:0]   q_prev, q_in;
      logic            hit;

      if (s == 0) begin : g_first
         assign r_prev = W_X'(num);
         assign d_prev = den;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[s-1];
         assign d_prev = d_ff[s-1];
         assign q_prev = q_ff[s-1];
      end

      always_comb begin
         d_sh = W_X'(d_prev) << (QB - 1 - s);
         hit  = r_prev >= d_sh;
         r_in = hit ? r_prev - d_sh : r_prev;
         q_in = {q_prev[QB-2:0], hit};
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            r_ff[s] <= r_in;
            d_ff[s] <= d_prev;
            q_ff[s] <= q_in;
         end
      end
   end

   assign quo = q_ff[QB-1];

endmodule
